FILE: design/u8d_pkg.sv
// Shared types, constants and helpers for the utf-8 byte stream decoder.
// No dependencies; used by every module of the decoder by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 31;
  localparam int unsigned PendW = 3;

  // continuation byte tag in the top two bits
  localparam logic [1:0] ContTag = 2'b10;

  // one decoded result word
  typedef struct packed {
    logic           valid;
    logic [CpW-1:0] code_point;
    logic           is_error;
    logic           ends_string;
  } result_t;

  // number of continuation bytes a lead byte announces
  function automatic logic [PendW-1:0] trail_count(input logic [ByteW-1:0] b);
    logic [PendW-1:0] n;
    begin
      if (b < 8'hC0)      n = 3'd0;
      else if (b < 8'hE0) n = 3'd1;
      else if (b < 8'hF0) n = 3'd2;
      else if (b < 8'hF8) n = 3'd3;
      else if (b < 8'hFC) n = 3'd4;
      else                n = 3'd5;
      return n;
    end
  endfunction

  // payload mask applied to a lead byte, by sequence length
  function automatic logic [6:0] lead_mask(input logic [PendW-1:0] n);
    logic [6:0] m;
    begin
      case (n)
        3'd0:    m = 7'h7f;
        3'd1:    m = 7'h1f;
        3'd2:    m = 7'h0f;
        3'd3:    m = 7'h07;
        3'd4:    m = 7'h03;
        3'd5:    m = 7'h01;
        default: m = 7'h00;
      endcase
      return m;
    end
  endfunction

endpackage
`default_nettype wire

FILE: design/u8d_in_reg.sv
// Input register stage of the utf-8 decoder: holds one byte word.
// Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module u8d_in_reg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [u8d_pkg::ByteW-1:0] in_byte_i,
  input  wire logic                      in_last_i,
  output logic                           valid_o,
  input  wire logic                      advance_i,
  output logic [u8d_pkg::ByteW-1:0]      byte_o,
  output logic                           last_o
);

  logic                      valid_q, valid_d;
  logic [u8d_pkg::ByteW-1:0] byte_q;
  logic                      last_q;
  logic                      load;

  // stage takes a word when empty or when its word moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  // control flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule
`default_nettype wire

FILE: design/u8d_core.sv
// Decode step of the utf-8 decoder: sequence state and one-byte update.
// Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module u8d_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      fire_i,
  input  wire logic [u8d_pkg::ByteW-1:0] byte_i,
  input  wire logic                      last_i,
  output u8d_pkg::result_t               result_o
);

  logic [u8d_pkg::PendW-1:0] pend_q, pend_d;
  logic [u8d_pkg::CpW-1:0]   partial_q, partial_d;
  logic                      drop_q, drop_d;
  logic [u8d_pkg::PendW-1:0] n;
  logic [u8d_pkg::PendW-1:0] pend_dec;
  logic [u8d_pkg::CpW-1:0]   shifted;
  logic                      fail;
  u8d_pkg::result_t          res;

  assign n        = u8d_pkg::trail_count(byte_i);
  assign pend_dec = pend_q - 3'd1;
  assign shifted  = {partial_q[u8d_pkg::CpW-7:0], byte_i[5:0]};

  // next state and result for the byte in the input stage
  always_comb begin
    pend_d    = pend_q;
    partial_d = partial_q;
    drop_d    = drop_q;
    fail      = 1'b0;
    res       = '0;
    if (drop_q) begin
      // discard the rest of the string
      if (last_i) begin
        drop_d = 1'b0;
      end
    end else if (pend_q == '0) begin
      // expecting a lead byte
      if (n == '0) begin
        if (byte_i[7]) begin
          fail = 1'b1;
        end else begin
          res.valid      = 1'b1;
          res.code_point = {24'd0, byte_i[6:0]};
        end
      end else if (last_i) begin
        fail = 1'b1;
      end else begin
        partial_d = {24'd0, byte_i[6:0] & u8d_pkg::lead_mask(n)};
        pend_d    = n;
      end
    end else if (byte_i[7:6] != u8d_pkg::ContTag) begin
      fail = 1'b1;
    end else if (pend_dec == '0) begin
      // sequence complete
      res.valid      = 1'b1;
      res.code_point = shifted;
      pend_d         = '0;
      partial_d      = '0;
    end else if (last_i) begin
      fail = 1'b1;
    end else begin
      partial_d = shifted;
      pend_d    = pend_dec;
    end
    if (fail) begin
      pend_d         = '0;
      partial_d      = '0;
      drop_d         = !last_i;
      res.valid      = 1'b1;
      res.code_point = '0;
      res.is_error   = 1'b1;
    end
    res.ends_string = last_i;
  end

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      partial_q <= '0;
      drop_q    <= 1'b0;
    end else if (fire_i) begin
      pend_q    <= pend_d;
      partial_q <= partial_d;
      drop_q    <= drop_d;
    end
  end

  assign result_o = res;

endmodule
`default_nettype wire

FILE: design/u8d_out_reg.sv
// Result register of the utf-8 decoder, facing the output stream.
// Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module u8d_out_reg (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    load_i,
  input  wire u8d_pkg::result_t        result_i,
  output logic                         space_o,
  output logic                         valid_o,
  input  wire logic                    ready_i,
  output logic [u8d_pkg::CpW-1:0]      code_point_o,
  output logic                         is_error_o,
  output logic                         ends_string_o
);

  logic                    valid_q, valid_d;
  logic [u8d_pkg::CpW-1:0] cp_q;
  logic                    err_q;
  logic                    last_q;

  // register can take a word when empty or drained this cycle
  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cp_q   <= result_i.code_point;
      err_q  <= result_i.is_error;
      last_q <= result_i.ends_string;
    end
  end

  assign valid_o       = valid_q;
  assign code_point_o  = cp_q;
  assign is_error_o    = err_q;
  assign ends_string_o = last_q;

endmodule
`default_nettype wire

FILE: design/utf8_byte_stream_decoder.sv
// Top level of the utf-8 byte stream decoder (legacy six-byte form).
// Depends on u8d_pkg, u8d_in_reg, u8d_core and u8d_out_reg.
`timescale 1ns / 1ps
`default_nettype none
// Decodes one byte word per clock while the result register is not stalled.
// A byte is registered on entry in the input register, decoded from there by
// the sequence state and, if it completes a character or hits an error,
// written to the result register. Lead bytes C0-FF open
// sequences of one to five continuation bytes with no overlong or range
// check. A stray or bad continuation byte, or a string that ends inside a
// sequence, gives an error word (code point zero, tuser high) and the rest
// of that string is dropped without results. Bytes that give no result
// move on even while the result register is stalled.
module utf8_byte_stream_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tlast_i,   // string_last
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [30:0] code_point, [31] zero
  output logic             m_axis_tuser_o,   // [0] is_error
  output logic             m_axis_tlast_o    // ends_string
);

  logic                      st_valid;
  logic                      advance;
  logic [u8d_pkg::ByteW-1:0] st_byte;
  logic                      st_last;
  logic                      out_space;
  logic                      out_load;
  logic [u8d_pkg::CpW-1:0]   cp;
  u8d_pkg::result_t          result;

  // input register
  u8d_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .valid_o    (st_valid),
    .advance_i  (advance),
    .byte_o     (st_byte),
    .last_o     (st_last)
  );

  // decode step
  u8d_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .byte_i   (st_byte),
    .last_i   (st_last),
    .result_o (result)
  );

  // a word moves on unless it has a result and the result register is full
  assign advance  = st_valid && (!result.valid || out_space);
  assign out_load = advance && result.valid;

  // result register
  u8d_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (out_load),
    .result_i      (result),
    .space_o       (out_space),
    .valid_o       (m_axis_tvalid_o),
    .ready_i       (m_axis_tready_i),
    .code_point_o  (cp),
    .is_error_o    (m_axis_tuser_o),
    .ends_string_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, cp};

endmodule
`default_nettype wire
